/* design/bse_pkg.sv */
package bse_pkg;

    localparam int MAX_CTRL_U_DEF    = 8;
    localparam int MAX_CTRL_V_DEF    = 8;
    localparam int MAX_SAMPLES_U_DEF = 256;
    localparam int MAX_SAMPLES_V_DEF = 256;

    localparam int COORD_W  = 24;
    localparam int Q16_W    = 17;
    localparam int CFG_W    = 9;
    localparam int CFG_IDX_W = 2;

    localparam logic [Q16_W-1:0] ONE_Q16 = 17'h10000;

    localparam logic [CFG_IDX_W-1:0] REG_CTRL_COUNT_U = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CTRL_COUNT_V = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLES_U    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLES_V    = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_PV,
        ST_W_MUL,
        ST_W_BIN,
        ST_W_POW,
        ST_MAC_RD,
        ST_MAC_ACC,
        ST_FIN
    } state_t;

    typedef logic [15:0][15:0][15:0] binom_tab_t;

    function automatic binom_tab_t gen_binom();
        binom_tab_t t;
        t = '0;
        for (int n = 0; n < 16; n++) begin
            t[n][0] = 16'd1;
            for (int k = 1; k <= n; k++) begin
                t[n][k] = t[n-1][k-1] + t[n-1][k];
            end
        end
        return t;
    endfunction

    localparam binom_tab_t BINOM = gen_binom();

    function automatic logic [Q16_W-1:0] mul_q16(input logic [Q16_W-1:0] a,
                                                 input logic [Q16_W-1:0] b);
        logic [2*Q16_W-1:0] p;
        p = a * b + (2*Q16_W)'(32768);
        return p[Q16_W+15:16];
    endfunction

endpackage

/* design/bse_div.sv */
module bse_div #(
    parameter int NW = 25,
    parameter int DW = 8
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic          done,
    output logic [NW-1:0] quot
);
    import bse_pkg::*;

    localparam int CNTW = $clog2(NW + 1);

    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic [DW-1:0]   rem_reg, rem_next;
    logic [NW-1:0]   quo_reg, quo_next;
    logic [DW-1:0]   den_reg, den_next;
    logic            done_reg, done_next;
    logic [DW:0]     trial;

    always_comb begin
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[NW-1]};
        if (start) begin
            cnt_next = CNTW'(NW);
            rem_next = '0;
            quo_next = num;
            den_next = den;
        end else if (cnt_reg != '0) begin
            cnt_next = cnt_reg - 1'b1;
            if (trial >= {1'b0, den_reg}) begin
                rem_next = DW'(trial - {1'b0, den_reg});
                quo_next = {quo_reg[NW-2:0], 1'b1};
            end else begin
                rem_next = trial[DW-1:0];
                quo_next = {quo_reg[NW-2:0], 1'b0};
            end
            done_next = (cnt_reg == CNTW'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quot = quo_reg;

endmodule

/* design/bse_grid.sv */
module bse_grid #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                      aclk,
    input  logic                      we,
    input  logic [AW-1:0]             waddr,
    input  logic [3*bse_pkg::COORD_W-1:0] wdata,
    input  logic [AW-1:0]             raddr,
    output logic [3*bse_pkg::COORD_W-1:0] rdata
);
    import bse_pkg::*;

    logic [3*COORD_W-1:0] ram [DEPTH];
    logic [3*COORD_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            ram[waddr] <= wdata;
        end
        rdata_reg <= ram[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* design/bezier_surface_eval_top.sv */
// Tensor-product Bezier surface evaluator. A load word (tuser = 0) writes one
// control point into the grid memory when its row and column are in range. An
// evaluate word (tuser = 1) returns one saturated Q7.16 point. Per direction an
// evaluation runs the one-bit-per-cycle divider, then n-1 power steps and 3n
// weight steps with 17x17 Q16 multiplies; then, per grid entry, one memory read
// and three coordinate multiply-accumulates. The word's accept and the final round
// out come around these steps. A result not yet taken holds the next evaluation
// in its final state. Unwritten grid entries read as undefined.
module bezier_surface_eval_top #(
    parameter int MAX_CTRL_U    = bse_pkg::MAX_CTRL_U_DEF,
    parameter int MAX_CTRL_V    = bse_pkg::MAX_CTRL_V_DEF,
    parameter int MAX_SAMPLES_U = bse_pkg::MAX_SAMPLES_U_DEF,
    parameter int MAX_SAMPLES_V = bse_pkg::MAX_SAMPLES_V_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // grid_row, grid_col, ctrl_x, ctrl_y, ctrl_z, sample_u, sample_v
    input  logic [95:0]                   s_tdata,
    // req_type
    input  logic                          s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // surf_x, surf_y, surf_z
    output logic [71:0]                   m_tdata,
    input  logic                          cfg_we,
    input  logic [bse_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  logic [bse_pkg::CFG_W-1:0]     cfg_wdata
);
    import bse_pkg::*;

    localparam int MAXC  = (MAX_CTRL_U > MAX_CTRL_V) ? MAX_CTRL_U : MAX_CTRL_V;
    localparam int MAXS  = (MAX_SAMPLES_U > MAX_SAMPLES_V) ? MAX_SAMPLES_U : MAX_SAMPLES_V;
    localparam int KW    = $clog2(MAXC);
    localparam int UIW   = $clog2(MAX_CTRL_U);
    localparam int VIW   = $clog2(MAX_CTRL_V);
    localparam int DW    = $clog2(MAXS);
    localparam int NW    = DW + 17;
    localparam int DEPTH = MAX_CTRL_U * MAX_CTRL_V;
    localparam int GW    = $clog2(DEPTH);
    localparam int AW    = 2 + Q16_W + COORD_W + GW;
    localparam int QW    = AW - 16;

    state_t state_reg, state_next;

    logic [3:0] ccu_reg, ccv_reg;
    logic [8:0] su_reg, sv_reg;

    logic            dim_reg, dim_next;
    logic [KW-1:0]   k_reg, k_next;
    logic [KW-1:0]   a_reg, a_next, b_reg, b_next;
    logic [1:0]      c_reg, c_next;
    logic [Q16_W-1:0] u_reg, u_next, pu_reg, pu_next, prod_reg, prod_next;
    logic [Q16_W-1:0] w2_reg, w2_next;
    logic [Q16_W-1:0] pv_mem [MAXC];
    logic [Q16_W-1:0] wu_reg [MAX_CTRL_U];
    logic [Q16_W-1:0] wv_reg [MAX_CTRL_V];
    logic [7:0]      iu_reg, iv_reg;
    logic signed [AW-1:0] acc_reg [3];
    logic signed [AW-1:0] acc_next [3];
    logic [71:0]     out_reg, out_next;
    logic            mv_reg, mv_next;

    logic            pv_we, wu_we, wv_we;
    logic [KW-1:0]   pv_waddr;
    logic [Q16_W-1:0] pv_wdata, w_wdata;

    logic [KW-1:0]   degu, degv, deg;
    logic [DW-1:0]   den;
    logic [NW-1:0]   num;
    logic            div_start, div_done;
    logic [NW-1:0]   div_quot;
    logic [GW-1:0]   raddr;
    logic [71:0]     rdata;
    logic            s_acc, load_we;
    logic [GW-1:0]   waddr;
    logic [Q16_W-1:0] mul_res;
    logic [Q16_W+15:0] bin_t;
    logic signed [Q16_W+COORD_W:0] mac_p;
    logic [COORD_W-1:0] coord;

    function automatic logic [KW-1:0] clamp_deg(input logic [3:0] c, input int mx);
        int n;
        n = int'(c);
        if (n < 2) n = 2;
        if (n > mx) n = mx;
        return KW'(n - 1);
    endfunction

    function automatic logic [COORD_W-1:0] round_sat(input logic signed [AW-1:0] acc);
        logic signed [AW-1:0] t;
        logic signed [QW-1:0] q;
        t = acc + AW'(32768);
        q = QW'(t >>> 16);
        if (q > QW'(8388607)) return 24'h7FFFFF;
        if (q < -QW'(8388608)) return 24'h800000;
        return q[COORD_W-1:0];
    endfunction

    assign degu = clamp_deg(ccu_reg, MAX_CTRL_U);
    assign degv = clamp_deg(ccv_reg, MAX_CTRL_V);
    assign deg  = dim_reg ? degv : degu;

    always_comb begin
        int s, mx, ix;
        mx = dim_reg ? MAX_SAMPLES_V : MAX_SAMPLES_U;
        s  = dim_reg ? int'(sv_reg) : int'(su_reg);
        ix = dim_reg ? int'(iv_reg) : int'(iu_reg);
        if (s < 2) s = 2;
        if (s > mx) s = mx;
        if (ix > s - 1) ix = s - 1;
        den = DW'(s - 1);
        num = (NW'(ix) << 16) + NW'((s - 1) / 2);
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_acc     = s_tvalid && s_tready;
    assign waddr     = GW'(32'(s_tdata[2:0]) * MAX_CTRL_V + 32'(s_tdata[5:3]));
    assign load_we   = s_acc && !s_tuser && (32'(s_tdata[2:0]) < MAX_CTRL_U)
                       && (32'(s_tdata[5:3]) < MAX_CTRL_V);
    assign raddr     = GW'(32'(a_reg) * MAX_CTRL_V + 32'(b_reg));
    assign div_start = (state_reg == ST_DIV_START);

    bse_div #(.NW(NW), .DW(DW)) u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start), .num(num), .den(den),
        .done(div_done), .quot(div_quot)
    );

    bse_grid #(.DEPTH(DEPTH), .AW(GW)) u_grid (
        .aclk(aclk), .we(load_we), .waddr(waddr), .wdata(s_tdata[77:6]),
        .raddr(raddr), .rdata(rdata)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:      if (s_acc && s_tuser) state_next = ST_DIV_START;
            ST_DIV_START: state_next = ST_DIV_WAIT;
            ST_DIV_WAIT:  if (div_done) state_next = ST_PV;
            ST_PV:        if (k_reg == deg) state_next = ST_W_MUL;
            ST_W_MUL:     state_next = ST_W_BIN;
            ST_W_BIN:     state_next = ST_W_POW;
            ST_W_POW: begin
                if (k_reg != deg) state_next = ST_W_MUL;
                else if (!dim_reg) state_next = ST_DIV_START;
                else state_next = ST_MAC_RD;
            end
            ST_MAC_RD:    state_next = ST_MAC_ACC;
            ST_MAC_ACC: begin
                if (c_reg == 2'd2) begin
                    if (b_reg == degv && a_reg == degu) state_next = ST_FIN;
                    else state_next = ST_MAC_RD;
                end
            end
            ST_FIN:       if (!mv_reg || m_tready) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        dim_next  = dim_reg;
        k_next    = k_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        c_next    = c_reg;
        u_next    = u_reg;
        pu_next   = pu_reg;
        prod_next = prod_reg;
        w2_next   = w2_reg;
        out_next  = out_reg;
        mv_next   = mv_reg;
        pv_we     = 1'b0;
        wu_we     = 1'b0;
        wv_we     = 1'b0;
        pv_waddr  = k_reg;
        pv_wdata  = '0;
        w_wdata   = '0;
        mul_res   = '0;
        bin_t     = '0;
        mac_p     = '0;
        coord     = '0;
        for (int i = 0; i < 3; i++) acc_next[i] = acc_reg[i];
        if (mv_reg && m_tready) mv_next = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                dim_next = 1'b0;
                for (int i = 0; i < 3; i++) acc_next[i] = '0;
            end
            ST_DIV_WAIT: begin
                if (div_done) begin
                    u_next   = (div_quot > NW'(ONE_Q16)) ? ONE_Q16 : div_quot[Q16_W-1:0];
                    pu_next  = ONE_Q16;
                    pv_we    = 1'b1;
                    pv_waddr = '0;
                    pv_wdata = ONE_Q16;
                    k_next   = KW'(1);
                end
            end
            ST_PV: begin
                mul_res  = mul_q16(pu_reg, ONE_Q16 - u_reg);
                pv_we    = 1'b1;
                pv_wdata = mul_res;
                if (k_reg == deg) begin
                    k_next  = '0;
                    pu_next = ONE_Q16;
                end else begin
                    k_next  = k_reg + 1'b1;
                    pu_next = mul_res;
                end
            end
            ST_W_MUL: begin
                prod_next = mul_q16(pu_reg, pv_mem[deg - k_reg]);
            end
            ST_W_BIN: begin
                bin_t   = BINOM[4'(deg)][4'(k_reg)] * prod_reg;
                w_wdata = (bin_t > (Q16_W+16)'(ONE_Q16)) ? ONE_Q16 : bin_t[Q16_W-1:0];
                wu_we   = !dim_reg;
                wv_we   = dim_reg;
            end
            ST_W_POW: begin
                pu_next = mul_q16(pu_reg, u_reg);
                if (k_reg != deg) begin
                    k_next = k_reg + 1'b1;
                end else begin
                    dim_next = 1'b1;
                    a_next   = '0;
                    b_next   = '0;
                end
            end
            ST_MAC_RD: begin
                w2_next = mul_q16(wu_reg[a_reg[UIW-1:0]], wv_reg[b_reg[VIW-1:0]]);
                c_next  = '0;
            end
            ST_MAC_ACC: begin
                case (c_reg)
                    2'd0:    coord = rdata[23:0];
                    2'd1:    coord = rdata[47:24];
                    default: coord = rdata[71:48];
                endcase
                mac_p = $signed({1'b0, w2_reg}) * $signed(coord);
                acc_next[c_reg] = acc_reg[c_reg] + AW'(mac_p);
                if (c_reg == 2'd2) begin
                    if (b_reg == degv) begin
                        b_next = '0;
                        a_next = a_reg + 1'b1;
                    end else begin
                        b_next = b_reg + 1'b1;
                    end
                end else begin
                    c_next = c_reg + 1'b1;
                end
            end
            ST_FIN: begin
                if (!mv_reg || m_tready) begin
                    out_next = {round_sat(acc_reg[2]), round_sat(acc_reg[1]),
                                round_sat(acc_reg[0])};
                    mv_next  = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            mv_reg    <= 1'b0;
            ccu_reg   <= 4'd5;
            ccv_reg   <= 4'd5;
            su_reg    <= 9'd16;
            sv_reg    <= 9'd16;
        end else begin
            state_reg <= state_next;
            mv_reg    <= mv_next;
            if (cfg_we) begin
                case (cfg_addr)
                    REG_CTRL_COUNT_U: ccu_reg <= cfg_wdata[3:0];
                    REG_CTRL_COUNT_V: ccv_reg <= cfg_wdata[3:0];
                    REG_SAMPLES_U:    su_reg  <= cfg_wdata;
                    REG_SAMPLES_V:    sv_reg  <= cfg_wdata;
                    default: ;
                endcase
            end
        end
        dim_reg  <= dim_next;
        k_reg    <= k_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        c_reg    <= c_next;
        u_reg    <= u_next;
        pu_reg   <= pu_next;
        prod_reg <= prod_next;
        w2_reg   <= w2_next;
        out_reg  <= out_next;
        for (int i = 0; i < 3; i++) acc_reg[i] <= acc_next[i];
        if (s_acc && s_tuser) begin
            iu_reg <= s_tdata[85:78];
            iv_reg <= s_tdata[93:86];
        end
        if (pv_we) pv_mem[pv_waddr] <= pv_wdata;
        if (wu_we) wu_reg[k_reg[UIW-1:0]] <= w_wdata;
        if (wv_we) wv_reg[k_reg[VIW-1:0]] <= w_wdata;
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = out_reg;

    a_div_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> state_reg == ST_DIV_WAIT) else $error("divider done out of place");
    a_eval_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc && s_tuser |=> state_reg == ST_DIV_START) else $error("evaluate not started");
    a_mac_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_MAC_RD |-> a_reg <= degu && b_reg <= degv)
        else $error("grid index out of range");
    a_fin_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_FIN && state_next == ST_IDLE |=> m_tvalid)
        else $error("result lost");

endmodule
